### rtl/mbe_pkg.sv
package mbe_pkg;

    localparam int IMAGE_WIDTH  = 512;
    localparam int IMAGE_HEIGHT = 512;

    localparam int PIX_W      = 9;
    localparam int COUNT_W    = 12;
    localparam int COLOR_W    = 26;
    localparam int STEP_W     = 31;
    localparam int COORD_W    = 32;
    localparam int WIDE_W     = 64;
    localparam int FRAC_BITS  = 28;
    localparam int SCALE_W    = 14;
    // signed pixel offset from centre; covers half sizes up to 2048
    localparam int DIFF_W     = 13;
    localparam int PROD_W     = DIFF_W + STEP_W + 1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_STEP_X          = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_STEP_Y          = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X        = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y        = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_ITERATION_LIMIT = CFG_IDX_W'(4);

    localparam logic [STEP_W-1:0]         STEP_RESET  = STEP_W'(1048576);
    localparam logic signed [COORD_W-1:0] OFFSET_RESET = '0;
    localparam logic [COUNT_W-1:0]        LIMIT_RESET = COUNT_W'(1000);

    localparam logic signed [DIFF_W-1:0] HALF_WIDTH  = DIFF_W'(IMAGE_WIDTH / 2);
    localparam logic signed [DIFF_W-1:0] HALF_HEIGHT = DIFF_W'(IMAGE_HEIGHT / 2);

    localparam logic [SCALE_W-1:0] COLOR_SCALE  = SCALE_W'(10000);
    localparam logic [WIDE_W-1:0]  ESCAPE_BOUND = WIDE_W'(4) << (2 * FRAC_BITS);

    typedef struct packed {
        logic [STEP_W-1:0]         step_x;
        logic [STEP_W-1:0]         step_y;
        logic signed [COORD_W-1:0] offset_x;
        logic signed [COORD_W-1:0] offset_y;
        logic [COUNT_W-1:0]        iteration_limit;
    } cfg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
    } coord_t;

    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] max_v;
        logic signed [WIDE_W-1:0] min_v;
        max_v = WIDE_W'(32'sh7fffffff);
        min_v = -max_v - WIDE_W'(1);
        if (v > max_v)
        begin
            return COORD_W'(max_v);
        end
        else if (v < min_v)
        begin
            return COORD_W'(min_v);
        end
        return v[COORD_W-1:0];
    endfunction

    function automatic logic signed [COORD_W-1:0] map_coord(
        input logic [PIX_W-1:0]          pix,
        input logic signed [DIFF_W-1:0]  half,
        input logic [STEP_W-1:0]         step,
        input logic signed [COORD_W-1:0] off
    );
        logic signed [DIFF_W-1:0] d;
        logic signed [PROD_W-1:0] prod;
        logic signed [WIDE_W-1:0] sum;
        d    = signed'({{(DIFF_W-PIX_W){1'b0}}, pix}) - half;
        prod = PROD_W'(d) * signed'(PROD_W'({1'b0, step}));
        sum  = WIDE_W'(prod) + WIDE_W'(off);
        return sat32(sum);
    endfunction

endpackage

### rtl/mbe_if.sv
interface mbe_pixel_if;
    import mbe_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_col;
    logic [PIX_W-1:0] pixel_row;

    modport source (output valid, pixel_col, pixel_row, input ready);
    modport sink   (input valid, pixel_col, pixel_row, output ready);
endinterface

interface mbe_result_if;
    import mbe_pkg::*;

    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] escape_count;
    logic [COLOR_W-1:0] pixel_color;

    modport source (output valid, escape_count, pixel_color, input ready);
    modport sink   (input valid, escape_count, pixel_color, output ready);
endinterface

### rtl/mbe_front.sv
module mbe_front (
    input  logic            clk,
    input  logic            rst_n,
    mbe_pixel_if.sink       pixel,
    input  mbe_pkg::cfg_t   cfg,
    output logic            push,
    output mbe_pkg::coord_t push_data,
    input  logic            full
);
    import mbe_pkg::*;

    logic             valid_reg;
    logic             valid_next;
    logic [PIX_W-1:0] col_reg;
    logic [PIX_W-1:0] row_reg;
    logic             take;

    assign push        = valid_reg && !full;
    assign pixel.ready = !valid_reg || !full;
    assign take        = pixel.valid && pixel.ready;

    assign push_data.cx = map_coord(col_reg, HALF_WIDTH, cfg.step_x, cfg.offset_x);
    assign push_data.cy = map_coord(row_reg, HALF_HEIGHT, cfg.step_y, cfg.offset_y);

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            col_reg <= pixel.pixel_col;
            row_reg <= pixel.pixel_row;
        end
    end
endmodule

### rtl/mbe_queue.sv
module mbe_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  mbe_pkg::coord_t push_data,
    output logic            full,
    input  logic            pop,
    output mbe_pkg::coord_t pop_data,
    output logic            empty
);
    import mbe_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    coord_t             data_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic               do_push;
    logic               do_pop;

    assign full     = cnt_reg == CNT_W'(DEPTH);
    assign empty    = cnt_reg == '0;
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = data_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            data_reg[wr_ptr_reg] <= push_data;
        end
    end
endmodule

### rtl/mbe_iter.sv
module mbe_iter (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [mbe_pkg::COUNT_W-1:0]   iteration_limit,
    input  logic                          empty,
    input  mbe_pkg::coord_t               pop_data,
    output logic                          pop,
    mbe_result_if.source                  result
);
    import mbe_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_TEST = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]                state_reg;
    logic [1:0]                state_next;
    logic signed [COORD_W-1:0] cx_reg;
    logic signed [COORD_W-1:0] cy_reg;
    logic signed [COORD_W-1:0] zx_reg;
    logic signed [COORD_W-1:0] zy_reg;
    logic signed [WIDE_W-1:0]  xx_reg;
    logic signed [WIDE_W-1:0]  yy_reg;
    logic signed [WIDE_W-1:0]  xy_reg;
    logic [COUNT_W-1:0]        count_reg;
    logic [COUNT_W-1:0]        final_reg;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [COUNT_W-1:0]        out_count_reg;
    logic [COLOR_W-1:0]        out_color_reg;

    logic [WIDE_W-1:0]         mag;
    logic                      escape;
    logic                      at_limit;
    logic signed [WIDE_W-1:0]  diff;
    logic signed [COORD_W-1:0] nx;
    logic signed [COORD_W-1:0] ny;
    logic                      load_out;
    logic [COUNT_W+SCALE_W-1:0] color_full;

    assign pop      = (state_reg == ST_IDLE) && !empty;
    assign mag      = WIDE_W'(xx_reg) + WIDE_W'(yy_reg);
    assign escape   = mag >= ESCAPE_BOUND;
    assign at_limit = count_reg >= iteration_limit;
    assign diff     = xx_reg - yy_reg;
    assign nx       = sat32((diff >>> FRAC_BITS) + WIDE_W'(cx_reg));
    assign ny       = sat32((xy_reg >>> (FRAC_BITS - 1)) + WIDE_W'(cy_reg));
    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || result.ready);
    assign color_full = (COUNT_W+SCALE_W)'(final_reg) * (COUNT_W+SCALE_W)'(COLOR_SCALE);

    assign result.valid        = out_valid_reg;
    assign result.escape_count = out_count_reg;
    assign result.pixel_color  = out_color_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_TEST;
            end
            ST_TEST:
            begin
                if (at_limit || escape)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_MUL;
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cx_reg    <= pop_data.cx;
            cy_reg    <= pop_data.cy;
            zx_reg    <= '0;
            zy_reg    <= '0;
            count_reg <= '0;
        end
        if (state_reg == ST_MUL)
        begin
            xx_reg <= WIDE_W'(zx_reg) * WIDE_W'(zx_reg);
            yy_reg <= WIDE_W'(zy_reg) * WIDE_W'(zy_reg);
            xy_reg <= WIDE_W'(zx_reg) * WIDE_W'(zy_reg);
        end
        if (state_reg == ST_TEST)
        begin
            if (at_limit)
            begin
                final_reg <= '0;
            end
            else if (escape)
            begin
                final_reg <= count_reg;
            end
            else
            begin
                zx_reg    <= nx;
                zy_reg    <= ny;
                count_reg <= count_reg + COUNT_W'(1);
            end
        end
        if (load_out)
        begin
            out_count_reg <= final_reg;
            out_color_reg <= color_full[COLOR_W-1:0];
        end
    end
endmodule

### rtl/mbe_core.sv
module mbe_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [mbe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mbe_pkg::CFG_DATA_W-1:0] cfg_data,
    output mbe_pkg::cfg_t                cfg
);
    import mbe_pkg::*;

    cfg_t cfg_reg;

    assign cfg = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_x          <= STEP_RESET;
            cfg_reg.step_y          <= STEP_RESET;
            cfg_reg.offset_x        <= OFFSET_RESET;
            cfg_reg.offset_y        <= OFFSET_RESET;
            cfg_reg.iteration_limit <= LIMIT_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_STEP_X:          cfg_reg.step_x          <= cfg_data[STEP_W-1:0];
                REG_STEP_Y:          cfg_reg.step_y          <= cfg_data[STEP_W-1:0];
                REG_OFFSET_X:        cfg_reg.offset_x        <= signed'(cfg_data[COORD_W-1:0]);
                REG_OFFSET_Y:        cfg_reg.offset_y        <= signed'(cfg_data[COORD_W-1:0]);
                REG_ITERATION_LIMIT: cfg_reg.iteration_limit <= cfg_data[COUNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end
endmodule

### rtl/mandelbrot_escape_time.sv
// channel   dir  handshake         payload
// pixel     in   valid / ready     pixel_col[8:0], pixel_row[8:0]
// result    out  valid / ready     escape_count[11:0], pixel_color[25:0]
// cfg       in   cfg_wr_en         cfg_index[2:0], cfg_data[31:0]
//
// The iteration unit works on one pixel at a time, alternating a single z*z multiply
// stage and an escape test and update stage until the pixel escapes or reaches the limit.
// The mapping stage takes a pixel each cycle while the queue has room, and a two-entry queue holds mapped points.
// Reset clears all control state and loads the register defaults at once.
// The result register holds a finished pixel while the next one is taken in.
module mandelbrot_escape_time (
    input  logic                           clk,
    input  logic                           rst_n,
    mbe_pixel_if.sink                      pixel,
    mbe_result_if.source                   result,
    input  logic                           cfg_wr_en,
    input  logic [mbe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mbe_pkg::CFG_DATA_W-1:0] cfg_data
);
    import mbe_pkg::*;

    cfg_t   cfg;
    logic   push;
    coord_t push_data;
    logic   full;
    logic   pop;
    coord_t pop_data;
    logic   empty;

    mbe_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mbe_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel     (pixel),
        .cfg       (cfg),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    mbe_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    mbe_iter u_iter (
        .clk             (clk),
        .rst_n           (rst_n),
        .iteration_limit (cfg.iteration_limit),
        .empty           (empty),
        .pop_data        (pop_data),
        .pop             (pop),
        .result          (result)
    );
endmodule

### tb/escape_checker.sv
`timescale 1ns / 100ps

module escape_checker
    import mbe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    mbe_pixel_if                  pixel,
    mbe_result_if                 result,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    waiting,
    output int                    results_seen
);

    typedef struct packed {
        logic [COUNT_W-1:0] escape_count;
        logic [COLOR_W-1:0] pixel_color;
    } pixel_result_t;

    logic [STEP_W-1:0]         view_step_x;
    logic [STEP_W-1:0]         view_step_y;
    logic signed [COORD_W-1:0] view_off_x;
    logic signed [COORD_W-1:0] view_off_y;
    logic [COUNT_W-1:0]        iter_limit;

    pixel_result_t awaited_pixels[$];

    function automatic logic signed [COORD_W-1:0] clip32(input longint v);
        if (v > 64'sd2147483647)
        begin
            return 32'sh7fff_ffff;
        end
        if (v < -64'sd2147483648)
        begin
            return 32'sh8000_0000;
        end
        return v[COORD_W-1:0];
    endfunction

    function automatic logic signed [COORD_W-1:0] to_plane(
        input logic [PIX_W-1:0]          pix,
        input int                        half,
        input logic [STEP_W-1:0]         step,
        input logic signed [COORD_W-1:0] off
    );
        longint d;
        d = longint'(pix) - longint'(half);
        return clip32(d * longint'(step) + longint'(off));
    endfunction

    function automatic pixel_result_t escape_time(
        input logic [PIX_W-1:0] col,
        input logic [PIX_W-1:0] row
    );
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] zx;
        logic signed [COORD_W-1:0] zy;
        logic signed [COORD_W-1:0] nx;
        longint                    xx;
        longint                    yy;
        longint                    xy;
        logic [64:0]               mag;
        int unsigned               n;
        pixel_result_t             r;
        cx = to_plane(col, IMAGE_WIDTH / 2, view_step_x, view_off_x);
        cy = to_plane(row, IMAGE_HEIGHT / 2, view_step_y, view_off_y);
        zx = '0;
        zy = '0;
        n  = 0;
        while (n < iter_limit)
        begin
            xx  = longint'(zx) * longint'(zx);
            yy  = longint'(zy) * longint'(zy);
            xy  = longint'(zx) * longint'(zy);
            mag = 65'(xx) + 65'(yy);
            if (mag >= (65'd4 << (2 * FRAC_BITS)))
            begin
                break;
            end
            nx = clip32(((xx - yy) >>> FRAC_BITS) + longint'(cx));
            zy = clip32((xy >>> (FRAC_BITS - 1)) + longint'(cy));
            zx = nx;
            n++;
        end
        if (n >= iter_limit)
        begin
            n = 0;
        end
        r.escape_count = COUNT_W'(n);
        r.pixel_color  = COLOR_W'(n * 10000);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pixel_result_t want;
        if (!rst_n)
        begin
            view_step_x  = STEP_RESET;
            view_step_y  = STEP_RESET;
            view_off_x   = OFFSET_RESET;
            view_off_y   = OFFSET_RESET;
            iter_limit   = LIMIT_RESET;
            awaited_pixels.delete();
            mismatches   = 0;
            results_seen = 0;
            waiting      = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_STEP_X:          view_step_x = cfg_data[STEP_W-1:0];
                    REG_STEP_Y:          view_step_y = cfg_data[STEP_W-1:0];
                    REG_OFFSET_X:        view_off_x  = signed'(cfg_data[COORD_W-1:0]);
                    REG_OFFSET_Y:        view_off_y  = signed'(cfg_data[COORD_W-1:0]);
                    REG_ITERATION_LIMIT: iter_limit  = cfg_data[COUNT_W-1:0];
                    default:             ;
                endcase
            end
            if (result.valid && result.ready)
            begin
                if (awaited_pixels.size() == 0)
                begin
                    $error("unexpected result transfer: escape_count %0d, pixel_color %0d",
                           result.escape_count, result.pixel_color);
                    mismatches++;
                end
                else
                begin
                    want = awaited_pixels.pop_front();
                    results_seen++;
                    if (result.escape_count !== want.escape_count)
                    begin
                        $error("escape_count: expected %0d, actual %0d",
                               want.escape_count, result.escape_count);
                        mismatches++;
                    end
                    if (result.pixel_color !== want.pixel_color)
                    begin
                        $error("pixel_color: expected %0d, actual %0d",
                               want.pixel_color, result.pixel_color);
                        mismatches++;
                    end
                end
            end
            if (pixel.valid && pixel.ready)
            begin
                awaited_pixels.push_back(escape_time(pixel.pixel_col, pixel.pixel_row));
            end
            waiting = awaited_pixels.size();
        end
    end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import mbe_pkg::*;

    localparam int ROUNDS          = 12;
    localparam int PIXELS_PER_VIEW = 48;
    localparam int CYCLE_LIMIT     = 3_000_000;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int mismatches;
    int waiting;
    int results_seen;
    int send_gap_pct;
    int result_stall_pct;
    int pixels_sent;
    int views_loaded;
    int cycles;

    mbe_pixel_if  pixel ();
    mbe_result_if result ();

    mandelbrot_escape_time uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel     (pixel),
        .result    (result),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    escape_checker chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel        (pixel),
        .result       (result),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .waiting      (waiting),
        .results_seen (results_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("mandelbrot_escape_time: mismatch");
            $finish;
        end
    end

    initial
    begin
        result.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            result.ready <= ($urandom_range(99, 0) >= result_stall_pct);
        end
    end

    task automatic send_pixel(input logic [PIX_W-1:0] col, input logic [PIX_W-1:0] row);
        while ($urandom_range(99, 0) < send_gap_pct)
        begin
            pixel.valid <= 1'b0;
            @(negedge clk);
        end
        pixel.valid     <= 1'b1;
        pixel.pixel_col <= col;
        pixel.pixel_row <= row;
        do
        begin
            @(posedge clk);
        end
        while (!pixel.ready);
        pixels_sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        pixel.valid <= 1'b0;
        while (waiting != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
    endtask

    task automatic load_view(
        input logic [CFG_DATA_W-1:0] sx,
        input logic [CFG_DATA_W-1:0] sy,
        input logic [CFG_DATA_W-1:0] ox,
        input logic [CFG_DATA_W-1:0] oy,
        input logic [CFG_DATA_W-1:0] lim
    );
        drain();
        put_reg(REG_STEP_X, sx);
        put_reg(REG_STEP_Y, sy);
        put_reg(REG_OFFSET_X, ox);
        put_reg(REG_OFFSET_Y, oy);
        put_reg(REG_ITERATION_LIMIT, lim);
        cfg_wr_en <= 1'b0;
        views_loaded++;
    endtask

    initial
    begin
        logic [CFG_DATA_W-1:0] lim;
        rst_n            <= 1'b0;
        cfg_wr_en        <= 1'b0;
        cfg_index        <= REG_STEP_X;
        cfg_data         <= '0;
        pixel.valid      <= 1'b0;
        pixel.pixel_col  <= '0;
        pixel.pixel_row  <= '0;
        send_gap_pct     = 27;
        result_stall_pct = 78;
        pixels_sent      = 0;
        views_loaded     = 1;
        cycles           = 0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // register defaults: corners, centre and the period-two point
        send_pixel(9'd0, 9'd0);
        send_pixel(9'd511, 9'd511);
        send_pixel(9'd0, 9'd511);
        send_pixel(9'd511, 9'd0);
        send_pixel(9'd256, 9'd256);
        send_pixel(9'd0, 9'd256);

        load_view(32'd1048576, 32'd1048576, 32'h0, 32'h0, 32'd4095);
        send_pixel(9'd256, 9'd256);
        send_pixel(9'h155, 9'h0aa);
        send_pixel(9'h0aa, 9'h155);
        send_pixel(9'd511, 9'd0);

        // no iterations at all
        load_view(32'd1048576, 32'd1048576, 32'h0, 32'h0, 32'd0);
        send_pixel(9'd100, 9'd200);
        send_pixel(9'd511, 9'd511);

        load_view(32'd1048576, 32'd1048576, 32'h0, 32'h0, 32'd1);
        send_pixel(9'd256, 9'd256);

        // zero step: all pixels land on the offset point
        load_view(32'h0, 32'h0, 32'hf400_0000, 32'h0199_999a, 32'd50);
        send_pixel(9'd0, 9'd0);
        send_pixel(9'd511, 9'd511);

        // saturated mapping
        load_view(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'd4095);
        send_pixel(9'd511, 9'd0);
        send_pixel(9'd0, 9'd511);
        send_pixel(9'd256, 9'd256);

        load_view(32'd1, 32'd1, 32'h8000_0000, 32'h7fff_ffff, 32'd4095);
        send_pixel(9'd0, 9'd0);
        send_pixel(9'd511, 9'd511);

        for (int round = 0; round < ROUNDS; round++)
        begin
            if (round == ROUNDS / 3)
            begin
                send_gap_pct     = 78;
                result_stall_pct = 27;
            end
            else if (round == 2 * ROUNDS / 3)
            begin
                send_gap_pct     = 0;
                result_stall_pct = 0;
            end
            lim = (round % 4 == 3) ? $urandom_range(600, 121) : $urandom_range(120, 1);
            if (round % 4 == 1)
            begin
                load_view($urandom, $urandom, $urandom, $urandom, lim);
            end
            else
            begin
                // views around the set: real part -2.0 to 0.5, imaginary -1.0 to 1.0
                load_view($urandom_range(1 << 21, 1 << 12), $urandom_range(1 << 21, 1 << 12),
                          $urandom_range(671088640, 0) - 32'd536870912,
                          $urandom_range(536870912, 0) - 32'd268435456, lim);
            end
            repeat (PIXELS_PER_VIEW)
            begin
                send_pixel(PIX_W'($urandom_range(511, 0)), PIX_W'($urandom_range(511, 0)));
            end
        end

        drain();
        repeat (20) @(negedge clk);
        $display("%0d pixels sent over %0d register settings, %0d results compared",
                 pixels_sent, views_loaded, results_seen);
        $display("limits from 0 to 4095, zero and full-scale steps, saturated offsets");
        if (mismatches == 0)
        begin
            $display("mandelbrot_escape_time: match");
        end
        else
        begin
            $display("mandelbrot_escape_time: mismatch");
        end
        $finish;
    end

endmodule

### sim.f
rtl/mbe_pkg.sv
rtl/mbe_if.sv
rtl/mbe_front.sv
rtl/mbe_queue.sv
rtl/mbe_iter.sv
rtl/mbe_core.sv
rtl/mandelbrot_escape_time.sv
tb/escape_checker.sv
tb/tb_top.sv
